[hdl/lbdl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbdl_pkg
// Shared types, codes and helpers for the call button and RGB light block.
// ----------------------------------------------------------------------------
package lbdl_pkg;

    localparam int TIMER_WIDTH     = 16;
    localparam int ALARM_DEPTH_MAX = 255;
    localparam int DEPTH_WIDTH     = $clog2(ALARM_DEPTH_MAX + 1);
    localparam int CFG_WIDTH       = 16;
    localparam int DATA_WIDTH      = 32;
    localparam int ADDR_WIDTH      = 5;
    localparam int INDEX_WIDTH     = ADDR_WIDTH - 2;
    localparam int LED_COUNT       = 3;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [DEPTH_WIDTH-1:0] depth_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [LED_COUNT-1:0]   led_t;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_SET_COLOR = 2'd1,
        KIND_LIFT      = 2'd2,
        KIND_ALARM     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2,
        COLOR_NONE  = 2'd3
    } color_t;

    typedef enum logic [2:0] {
        LIFT_UP_MOVING   = 3'd0,
        LIFT_DOWN_MOVING = 3'd1,
        LIFT_UP          = 3'd2,
        LIFT_DOWN        = 3'd3,
        LIFT_STANDSTILL  = 3'd4
    } lift_t;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_REPEAT_GAP   = 3'd1,
        REG_BLINK_HALF   = 3'd2,
        REG_ALARM_PERIOD = 3'd3,
        REG_UPPER_FLOOR  = 3'd4
    } reg_index_t;

    localparam cfg_word_t RESET_DEBOUNCE     = 16'd50;
    localparam cfg_word_t RESET_REPEAT_GAP   = 16'd10000;
    localparam cfg_word_t RESET_BLINK_HALF   = 16'd700;
    localparam cfg_word_t RESET_ALARM_PERIOD = 16'd300;

    typedef struct packed {
        cfg_word_t debounce;
        cfg_word_t repeat_gap;
        cfg_word_t blink_half;
        cfg_word_t alarm_period;
        logic      upper_floor;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       button_raw;
        logic       sim_press;
        logic [1:0] color;
        logic       flashing;
        logic [2:0] lift_state;
        logic       alarm_on;
    } item_t;

    typedef struct packed {
        logic pressed;
        logic report;
        led_t led;
    } result_t;

    function automatic timer_t cap_limit(input cfg_word_t value);
        logic [63:0] wide;
        wide = 64'(value);
        if (wide > 64'(TIMER_MAX))
            return TIMER_MAX;
        return TIMER_WIDTH'(wide);
    endfunction

    function automatic timer_t count_up(input timer_t value);
        if (value == TIMER_MAX)
            return value;
        return value + 1'b1;
    endfunction

    function automatic led_t color_mask(input logic [1:0] color);
        if (color == COLOR_NONE)
            return '0;
        return led_t'(1) << color;
    endfunction

endpackage
`default_nettype wire

[hdl/lbdl_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbdl_cfg_regs
// APB register file holding the timer limits and the floor select.
// ----------------------------------------------------------------------------
module lbdl_cfg_regs
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lbdl_pkg::ADDR_WIDTH-1:0]     paddr,
    input  wire logic [lbdl_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic      [lbdl_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                     pready,
    output lbdl_pkg::cfg_t                           cfg
);

    lbdl_pkg::cfg_t                        cfg_reg;
    lbdl_pkg::cfg_t                        cfg_next;
    logic [lbdl_pkg::INDEX_WIDTH-1:0]      index;
    logic                                  write_fire;

    assign pready     = 1'b1;
    assign index      = paddr[lbdl_pkg::ADDR_WIDTH-1:2];
    assign write_fire = psel && penable && pwrite;
    assign cfg        = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_fire)
        begin
            unique case (index)
                lbdl_pkg::REG_DEBOUNCE:
                    cfg_next.debounce = pwdata[lbdl_pkg::CFG_WIDTH-1:0];
                lbdl_pkg::REG_REPEAT_GAP:
                    cfg_next.repeat_gap = pwdata[lbdl_pkg::CFG_WIDTH-1:0];
                lbdl_pkg::REG_BLINK_HALF:
                    cfg_next.blink_half = pwdata[lbdl_pkg::CFG_WIDTH-1:0];
                lbdl_pkg::REG_ALARM_PERIOD:
                    cfg_next.alarm_period = pwdata[lbdl_pkg::CFG_WIDTH-1:0];
                lbdl_pkg::REG_UPPER_FLOOR:
                    cfg_next.upper_floor = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            lbdl_pkg::REG_DEBOUNCE:
                prdata = lbdl_pkg::DATA_WIDTH'(cfg_reg.debounce);
            lbdl_pkg::REG_REPEAT_GAP:
                prdata = lbdl_pkg::DATA_WIDTH'(cfg_reg.repeat_gap);
            lbdl_pkg::REG_BLINK_HALF:
                prdata = lbdl_pkg::DATA_WIDTH'(cfg_reg.blink_half);
            lbdl_pkg::REG_ALARM_PERIOD:
                prdata = lbdl_pkg::DATA_WIDTH'(cfg_reg.alarm_period);
            lbdl_pkg::REG_UPPER_FLOOR:
                prdata = lbdl_pkg::DATA_WIDTH'(cfg_reg.upper_floor);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce     <= lbdl_pkg::RESET_DEBOUNCE;
            cfg_reg.repeat_gap   <= lbdl_pkg::RESET_REPEAT_GAP;
            cfg_reg.blink_half   <= lbdl_pkg::RESET_BLINK_HALF;
            cfg_reg.alarm_period <= lbdl_pkg::RESET_ALARM_PERIOD;
            cfg_reg.upper_floor  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

[hdl/lbdl_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbdl_core
// Debounce, report and blink timers, alarm nesting and LED state update.
// ----------------------------------------------------------------------------
module lbdl_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  lbdl_pkg::item_t       item,
    input  lbdl_pkg::cfg_t        cfg,
    output lbdl_pkg::result_t     result
);

    logic                 follow_reg,   follow_next;
    logic                 stable_reg,   stable_next;
    lbdl_pkg::timer_t     quiet_reg,    quiet_next;
    lbdl_pkg::timer_t     rcount_reg,   rcount_next;
    lbdl_pkg::timer_t     bcount_reg,   bcount_next;
    logic                 fast_reg,     fast_next;
    lbdl_pkg::depth_t     depth_reg,    depth_next;
    logic [1:0]           scolor_reg,   scolor_next;
    logic                 sflash_reg,   sflash_next;
    lbdl_pkg::led_t       lit_reg,      lit_next;
    lbdl_pkg::led_t       blinking_reg, blinking_next;

    logic                 level;
    logic                 report_flag;
    lbdl_pkg::timer_t     period;
    logic                 do_alarm;
    logic                 alarm_up;
    logic                 do_request;
    logic [1:0]           req_color;
    logic                 req_flash;
    logic                 lift_is_up;
    logic                 lift_alarm;

    assign level      = !item.button_raw || item.sim_press;
    assign lift_alarm = item.lift_state > lbdl_pkg::LIFT_STANDSTILL;
    assign lift_is_up = (item.lift_state == lbdl_pkg::LIFT_UP_MOVING)
                     || (item.lift_state == lbdl_pkg::LIFT_UP);
    assign period     = lbdl_pkg::cap_limit(fast_reg ? cfg.alarm_period
                                                     : cfg.blink_half);

    always_comb
    begin
        do_alarm   = (item.kind == lbdl_pkg::KIND_ALARM) || (item.kind == lbdl_pkg::KIND_LIFT);
        alarm_up   = (item.kind == lbdl_pkg::KIND_ALARM) ? item.alarm_on : lift_alarm;
        do_request = (item.kind == lbdl_pkg::KIND_SET_COLOR)
                  || ((item.kind == lbdl_pkg::KIND_LIFT) && !lift_alarm);
        if (item.kind == lbdl_pkg::KIND_SET_COLOR)
        begin
            req_color = item.color;
            req_flash = item.flashing;
        end
        else
        begin
            req_color = (lift_is_up == cfg.upper_floor) ? lbdl_pkg::COLOR_GREEN
                                                        : lbdl_pkg::COLOR_RED;
            req_flash = item.lift_state <= lbdl_pkg::LIFT_DOWN_MOVING;
        end
    end

    always_comb
    begin
        follow_next   = follow_reg;
        stable_next   = stable_reg;
        quiet_next    = quiet_reg;
        rcount_next   = rcount_reg;
        bcount_next   = bcount_reg;
        fast_next     = fast_reg;
        depth_next    = depth_reg;
        scolor_next   = scolor_reg;
        sflash_next   = sflash_reg;
        lit_next      = lit_reg;
        blinking_next = blinking_reg;
        report_flag   = 1'b0;

        if (item.kind == lbdl_pkg::KIND_TICK)
        begin
            if (level != follow_reg)
            begin
                follow_next = level;
                quiet_next  = '0;
            end
            else
            begin
                quiet_next = lbdl_pkg::count_up(quiet_reg);
            end
            if (quiet_next >= lbdl_pkg::cap_limit(cfg.debounce))
                stable_next = follow_next;

            rcount_next = lbdl_pkg::count_up(rcount_reg);
            if (stable_next != stable_reg)
            begin
                report_flag = 1'b1;
                rcount_next = '0;
            end
            else if (rcount_next >= lbdl_pkg::cap_limit(cfg.repeat_gap))
            begin
                report_flag = 1'b1;
                rcount_next = '0;
            end

            bcount_next = lbdl_pkg::count_up(bcount_reg);
            if (bcount_next >= period)
            begin
                lit_next    = lit_reg ^ blinking_reg;
                bcount_next = '0;
            end
        end

        if (do_alarm)
        begin
            if (alarm_up)
            begin
                if (depth_reg == '0)
                begin
                    lit_next      = lbdl_pkg::color_mask(lbdl_pkg::COLOR_RED);
                    blinking_next = lbdl_pkg::color_mask(lbdl_pkg::COLOR_RED);
                    fast_next     = 1'b1;
                    bcount_next   = '0;
                end
                if (depth_reg < lbdl_pkg::DEPTH_WIDTH'(lbdl_pkg::ALARM_DEPTH_MAX))
                    depth_next = depth_reg + 1'b1;
            end
            else
            begin
                if (depth_reg != '0)
                    depth_next = depth_reg - 1'b1;
                if (depth_next == '0)
                begin
                    lit_next      = lbdl_pkg::color_mask(scolor_reg);
                    blinking_next = sflash_reg ? lbdl_pkg::color_mask(scolor_reg) : '0;
                    fast_next     = 1'b0;
                    bcount_next   = '0;
                end
            end
        end

        if (do_request)
        begin
            scolor_next = req_color;
            sflash_next = req_flash;
            if (depth_next == '0)
            begin
                lit_next      = lbdl_pkg::color_mask(req_color);
                blinking_next = req_flash ? lbdl_pkg::color_mask(req_color) : '0;
            end
        end
    end

    assign result.pressed = stable_next;
    assign result.report  = report_flag;
    assign result.led     = lit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_reg   <= 1'b1;
            stable_reg   <= 1'b1;
            quiet_reg    <= '0;
            rcount_reg   <= '0;
            bcount_reg   <= '0;
            fast_reg     <= 1'b0;
            depth_reg    <= '0;
            scolor_reg   <= lbdl_pkg::COLOR_NONE;
            sflash_reg   <= 1'b0;
            lit_reg      <= '0;
            blinking_reg <= '0;
        end
        else if (fire)
        begin
            follow_reg   <= follow_next;
            stable_reg   <= stable_next;
            quiet_reg    <= quiet_next;
            rcount_reg   <= rcount_next;
            bcount_reg   <= bcount_next;
            fast_reg     <= fast_next;
            depth_reg    <= depth_next;
            scolor_reg   <= scolor_next;
            sflash_reg   <= sflash_next;
            lit_reg      <= lit_next;
            blinking_reg <= blinking_next;
        end
    end

endmodule
`default_nettype wire

[hdl/lit_button_debounce_and_led.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lit_button_debounce_and_led
// Call button debouncer with report strobe and blinking RGB light.
// Path: input register, core, output register; a result stall holds the word.
// Throughput: one word per cycle, set by the single state update pass, unless
// result_stall holds the output register.
// Reset: valid flags, core and config state reset at once, no clearing pass.
// ----------------------------------------------------------------------------
module lit_button_debounce_and_led
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic [1:0]                          kind,
    input  wire logic                                button_raw,
    input  wire logic                                sim_press,
    input  wire logic [1:0]                          color,
    input  wire logic                                flashing,
    input  wire logic [2:0]                          lift_state,
    input  wire logic                                alarm_on,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic                                     pressed,
    output logic                                     report,
    output logic                                     led_red,
    output logic                                     led_green,
    output logic                                     led_blue,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lbdl_pkg::ADDR_WIDTH-1:0]     paddr,
    input  wire logic [lbdl_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic      [lbdl_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                                     pready
);

    lbdl_pkg::cfg_t       cfg;
    lbdl_pkg::item_t      item_reg;
    logic                 item_valid_reg;
    lbdl_pkg::result_t    core_result;
    lbdl_pkg::result_t    result_reg;
    logic                 result_valid_reg;
    logic                 out_load;
    logic                 fire;
    logic                 accept;

    assign out_load   = !result_valid_reg || !result_stall;
    assign fire       = item_valid_reg && out_load;
    assign item_stall = item_valid_reg && !out_load;
    assign accept     = item_valid && !item_stall;

    lbdl_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lbdl_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                item_valid_reg <= 1'b1;
            else if (fire)
                item_valid_reg <= 1'b0;
            if (out_load)
                result_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind       <= kind;
            item_reg.button_raw <= button_raw;
            item_reg.sim_press  <= sim_press;
            item_reg.color      <= color;
            item_reg.flashing   <= flashing;
            item_reg.lift_state <= lift_state;
            item_reg.alarm_on   <= alarm_on;
        end
        if (fire)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign pressed      = result_reg.pressed;
    assign report       = result_reg.report;
    assign led_red      = result_reg.led[lbdl_pkg::COLOR_RED];
    assign led_green    = result_reg.led[lbdl_pkg::COLOR_GREEN];
    assign led_blue     = result_reg.led[lbdl_pkg::COLOR_BLUE];

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the call button debouncer and RGB light. A table of
// directed words runs first at the reset register values, then random phases
// run under several register settings, zero and full scale among them. Each
// accepted word goes through a local model of the station; the result words are
// compared field by field, in order, with the table's values or the model's.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIR_ROWS       = 24;
    localparam int IDLE_PCT       = 24;

    localparam lbdl_pkg::led_t LED_OFF = 3'b000;
    localparam lbdl_pkg::led_t LED_R   = 3'b001;
    localparam lbdl_pkg::led_t LED_G   = 3'b010;
    localparam lbdl_pkg::led_t LED_B   = 3'b100;

    localparam logic [2:0] LIFT_ALARM_LOW  = 3'd5;
    localparam logic [2:0] LIFT_ALARM_MID  = 3'd6;
    localparam logic [2:0] LIFT_ALARM_HIGH = 3'd7;

    localparam lbdl_pkg::result_t NO_RES = '0;

    typedef struct packed {
        lbdl_pkg::item_t   word;
        logic              known;
        lbdl_pkg::result_t res;
    } row_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            item_valid   = 1'b0;
    logic                            item_stall;
    logic [1:0]                      kind         = '0;
    logic                            button_raw   = 1'b1;
    logic                            sim_press    = 1'b0;
    logic [1:0]                      color        = '0;
    logic                            flashing     = 1'b0;
    logic [2:0]                      lift_state   = '0;
    logic                            alarm_on     = 1'b0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic                            pressed;
    logic                            report;
    logic                            led_red;
    logic                            led_green;
    logic                            led_blue;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [lbdl_pkg::ADDR_WIDTH-1:0] paddr        = '0;
    logic [lbdl_pkg::DATA_WIDTH-1:0] pwdata       = '0;
    logic [lbdl_pkg::DATA_WIDTH-1:0] prdata;
    logic                            pready;

    lit_button_debounce_and_led u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .button_raw   (button_raw),
        .sim_press    (sim_press),
        .color        (color),
        .flashing     (flashing),
        .lift_state   (lift_state),
        .alarm_on     (alarm_on),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pressed      (pressed),
        .report       (report),
        .led_red      (led_red),
        .led_green    (led_green),
        .led_blue     (led_blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // station model state
    lbdl_pkg::cfg_t     cfg_m;
    logic               follow_m;
    logic               stable_m;
    lbdl_pkg::timer_t   quiet_m;
    lbdl_pkg::timer_t   rpt_m;
    lbdl_pkg::timer_t   blink_m;
    logic               fast_m;
    lbdl_pkg::depth_t   depth_m;
    logic [1:0]         saved_color_m;
    logic               saved_flash_m;
    lbdl_pkg::led_t     lit_m;
    lbdl_pkg::led_t     blinking_m;

    lbdl_pkg::result_t  station_status_q[$];
    logic       calm        = 1'b0;
    int         errors      = 0;
    int         words_sent  = 0;
    int         results_seen = 0;
    int         reg_writes  = 0;
    int         reports_seen = 0;
    int         peak_depth  = 0;
    int         idle_cycles = 0;
    logic       btn_down    = 1'b0;

    function automatic lbdl_pkg::timer_t sat_inc(input lbdl_pkg::timer_t v);
        if (v == '1)
            return v;
        return v + 1'b1;
    endfunction

    function automatic void show_color(input logic [1:0] c, input logic blink);
        if (c == lbdl_pkg::COLOR_NONE)
        begin
            lit_m      = LED_OFF;
            blinking_m = LED_OFF;
        end
        else
        begin
            lit_m      = LED_R << c;
            blinking_m = blink ? (LED_R << c) : LED_OFF;
        end
    endfunction

    function automatic void alarm_step(input logic on);
        if (on)
        begin
            if (depth_m == 0)
            begin
                show_color(lbdl_pkg::COLOR_RED, 1'b1);
                fast_m  = 1'b1;
                blink_m = '0;
            end
            if (depth_m < lbdl_pkg::ALARM_DEPTH_MAX)
                depth_m = depth_m + 1'b1;
        end
        else
        begin
            if (depth_m > 0)
                depth_m = depth_m - 1'b1;
            if (depth_m == 0)
            begin
                show_color(saved_color_m, saved_flash_m);
                fast_m  = 1'b0;
                blink_m = '0;
            end
        end
        if (int'(depth_m) > peak_depth)
            peak_depth = int'(depth_m);
    endfunction

    function automatic void pick_color(input logic [1:0] c, input logic blink);
        saved_color_m = c;
        saved_flash_m = blink;
        if (depth_m == 0)
            show_color(c, blink);
    endfunction

    function automatic void reset_station();
        cfg_m.debounce     = lbdl_pkg::RESET_DEBOUNCE;
        cfg_m.repeat_gap   = lbdl_pkg::RESET_REPEAT_GAP;
        cfg_m.blink_half   = lbdl_pkg::RESET_BLINK_HALF;
        cfg_m.alarm_period = lbdl_pkg::RESET_ALARM_PERIOD;
        cfg_m.upper_floor  = 1'b0;
        follow_m      = 1'b1;
        stable_m      = 1'b1;
        quiet_m       = '0;
        rpt_m         = '0;
        blink_m       = '0;
        fast_m        = 1'b0;
        depth_m       = '0;
        saved_color_m = lbdl_pkg::COLOR_NONE;
        saved_flash_m = 1'b0;
        lit_m         = LED_OFF;
        blinking_m    = LED_OFF;
    endfunction

    function automatic lbdl_pkg::result_t advance_station(input lbdl_pkg::item_t w);
        lbdl_pkg::result_t r;
        logic              lvl;
        logic              was;
        logic              up;
        lbdl_pkg::timer_t  per;
        r.report = 1'b0;
        case (w.kind)
            lbdl_pkg::KIND_TICK:
            begin
                lvl = !w.button_raw || w.sim_press;
                was = stable_m;
                if (lvl != follow_m)
                begin
                    follow_m = lvl;
                    quiet_m  = '0;
                end
                else
                    quiet_m = sat_inc(quiet_m);
                if (quiet_m >= cfg_m.debounce)
                    stable_m = follow_m;
                rpt_m = sat_inc(rpt_m);
                if (stable_m != was || rpt_m >= cfg_m.repeat_gap)
                begin
                    r.report = 1'b1;
                    rpt_m    = '0;
                end
                blink_m = sat_inc(blink_m);
                per = fast_m ? cfg_m.alarm_period : cfg_m.blink_half;
                if (blink_m >= per)
                begin
                    lit_m   = lit_m ^ blinking_m;
                    blink_m = '0;
                end
            end
            lbdl_pkg::KIND_SET_COLOR:
                pick_color(w.color, w.flashing);
            lbdl_pkg::KIND_LIFT:
            begin
                if (w.lift_state > lbdl_pkg::LIFT_STANDSTILL)
                    alarm_step(1'b1);
                else
                begin
                    up = (w.lift_state == lbdl_pkg::LIFT_UP_MOVING)
                      || (w.lift_state == lbdl_pkg::LIFT_UP);
                    alarm_step(1'b0);
                    pick_color((up == cfg_m.upper_floor) ? lbdl_pkg::COLOR_GREEN
                                                         : lbdl_pkg::COLOR_RED,
                               w.lift_state <= lbdl_pkg::LIFT_DOWN_MOVING);
                end
            end
            default:
                alarm_step(w.alarm_on);
        endcase
        r.pressed = stable_m;
        r.led     = lit_m;
        return r;
    endfunction

    task automatic send_word(input lbdl_pkg::item_t w, input logic known,
                             input lbdl_pkg::result_t res);
        lbdl_pkg::result_t want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= w.kind;
        button_raw <= w.button_raw;
        sim_press  <= w.sim_press;
        color      <= w.color;
        flashing   <= w.flashing;
        lift_state <= w.lift_state;
        alarm_on   <= w.alarm_on;
        do
            @(posedge clk);
        while (item_stall);
        want = advance_station(w);
        station_status_q.push_back(known ? res : want);
        words_sent++;
    endtask

    task automatic write_reg(input lbdl_pkg::reg_index_t idx,
                             input lbdl_pkg::cfg_word_t val);
        logic [lbdl_pkg::DATA_WIDTH-1:0] word;
        word    = {16'($urandom), val};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lbdl_pkg::REG_DEBOUNCE:     cfg_m.debounce     = word[15:0];
            lbdl_pkg::REG_REPEAT_GAP:   cfg_m.repeat_gap   = word[15:0];
            lbdl_pkg::REG_BLINK_HALF:   cfg_m.blink_half   = word[15:0];
            lbdl_pkg::REG_ALARM_PERIOD: cfg_m.alarm_period = word[15:0];
            default:                    cfg_m.upper_floor  = word[0];
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (station_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic lbdl_pkg::item_t random_word();
        logic [$bits(lbdl_pkg::item_t)-1:0] bits;
        lbdl_pkg::item_t                    w;
        int                                 pick;
        bits = $bits(lbdl_pkg::item_t)'($urandom);
        w    = bits;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            w.kind = lbdl_pkg::KIND_TICK;
            if ($urandom_range(0, 99) < 4)
                btn_down = !btn_down;
            w.button_raw = !(btn_down ^ ($urandom_range(0, 99) < 10));
            w.sim_press  = ($urandom_range(0, 99) < 8);
        end
        else if (pick < 70)
            w.kind = lbdl_pkg::KIND_SET_COLOR;
        else if (pick < 85)
            w.kind = lbdl_pkg::KIND_LIFT;
        else
            w.kind = lbdl_pkg::KIND_ALARM;
        return w;
    endfunction

    task automatic run_phase(input lbdl_pkg::cfg_word_t deb, input lbdl_pkg::cfg_word_t intv,
                             input lbdl_pkg::cfg_word_t flash, input lbdl_pkg::cfg_word_t fast,
                             input logic upper, input int count, input logic burst);
        lbdl_pkg::item_t w;
        drain();
        write_reg(lbdl_pkg::REG_DEBOUNCE, deb);
        write_reg(lbdl_pkg::REG_REPEAT_GAP, intv);
        write_reg(lbdl_pkg::REG_BLINK_HALF, flash);
        write_reg(lbdl_pkg::REG_ALARM_PERIOD, fast);
        write_reg(lbdl_pkg::REG_UPPER_FLOOR, lbdl_pkg::cfg_word_t'(upper));
        if (burst)
        begin
            // push the alarm nesting past its ceiling
            for (int i = 0; i < lbdl_pkg::ALARM_DEPTH_MAX + 3; i++)
            begin
                w = random_word();
                if ($urandom_range(0, 3) == 0)
                begin
                    w.kind       = lbdl_pkg::KIND_LIFT;
                    w.lift_state = 3'($urandom_range(LIFT_ALARM_LOW, LIFT_ALARM_HIGH));
                end
                else
                begin
                    w.kind     = lbdl_pkg::KIND_ALARM;
                    w.alarm_on = 1'b1;
                end
                send_word(w, 1'b0, NO_RES);
            end
        end
        for (int i = 0; i < count; i++)
            send_word(random_word(), 1'b0, NO_RES);
    endtask

    row_t dir_rows [DIR_ROWS];

    initial
    begin
        reset_station();
        dir_rows = '{
            '{'{lbdl_pkg::KIND_TICK, 1'b1, 1'b0, lbdl_pkg::COLOR_NONE, 1'b1,
                LIFT_ALARM_HIGH, 1'b1},
              1'b1, '{1'b1, 1'b0, LED_OFF}},
            '{'{lbdl_pkg::KIND_TICK, 1'b0, 1'b0, lbdl_pkg::COLOR_RED, 1'b0,
                lbdl_pkg::LIFT_UP_MOVING, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_OFF}},
            '{'{lbdl_pkg::KIND_TICK, 1'b1, 1'b1, lbdl_pkg::COLOR_BLUE, 1'b1,
                lbdl_pkg::LIFT_STANDSTILL, 1'b0},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_SET_COLOR, 1'b1, 1'b1, lbdl_pkg::COLOR_RED, 1'b0,
                LIFT_ALARM_HIGH, 1'b1},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_SET_COLOR, 1'b0, 1'b0, lbdl_pkg::COLOR_GREEN, 1'b1,
                lbdl_pkg::LIFT_UP_MOVING, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_G}},
            '{'{lbdl_pkg::KIND_SET_COLOR, 1'b0, 1'b1, lbdl_pkg::COLOR_BLUE, 1'b1,
                lbdl_pkg::LIFT_DOWN, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_B}},
            '{'{lbdl_pkg::KIND_SET_COLOR, 1'b1, 1'b0, lbdl_pkg::COLOR_NONE, 1'b1,
                lbdl_pkg::LIFT_UP, 1'b1},
              1'b1, '{1'b1, 1'b0, LED_OFF}},
            '{'{lbdl_pkg::KIND_ALARM, 1'b0, 1'b0, lbdl_pkg::COLOR_NONE, 1'b0,
                lbdl_pkg::LIFT_UP_MOVING, 1'b1},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_ALARM, 1'b1, 1'b1, lbdl_pkg::COLOR_GREEN, 1'b1,
                LIFT_ALARM_HIGH, 1'b1},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_SET_COLOR, 1'b0, 1'b0, lbdl_pkg::COLOR_GREEN, 1'b0,
                lbdl_pkg::LIFT_UP_MOVING, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_ALARM, 1'b1, 1'b0, lbdl_pkg::COLOR_BLUE, 1'b1,
                lbdl_pkg::LIFT_DOWN, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_ALARM, 1'b0, 1'b1, lbdl_pkg::COLOR_RED, 1'b0,
                lbdl_pkg::LIFT_UP, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_G}},
            '{'{lbdl_pkg::KIND_ALARM, 1'b1, 1'b1, lbdl_pkg::COLOR_NONE, 1'b1,
                lbdl_pkg::LIFT_STANDSTILL, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_G}},
            '{'{lbdl_pkg::KIND_LIFT, 1'b0, 1'b0, lbdl_pkg::COLOR_NONE, 1'b0,
                LIFT_ALARM_LOW, 1'b0},
              1'b1, '{1'b1, 1'b0, LED_R}},
            '{'{lbdl_pkg::KIND_LIFT, 1'b1, 1'b1, lbdl_pkg::COLOR_BLUE, 1'b1,
                LIFT_ALARM_HIGH, 1'b0},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b0, 1'b1, lbdl_pkg::COLOR_GREEN, 1'b0,
                LIFT_ALARM_MID, 1'b1},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b1, 1'b0, lbdl_pkg::COLOR_RED, 1'b1,
                lbdl_pkg::LIFT_UP_MOVING, 1'b1},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b0, 1'b0, lbdl_pkg::COLOR_NONE, 1'b0,
                lbdl_pkg::LIFT_DOWN_MOVING, 1'b0},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b1, 1'b1, lbdl_pkg::COLOR_BLUE, 1'b1,
                lbdl_pkg::LIFT_UP, 1'b1},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b0, 1'b1, lbdl_pkg::COLOR_GREEN, 1'b0,
                lbdl_pkg::LIFT_DOWN, 1'b0},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_LIFT, 1'b1, 1'b0, lbdl_pkg::COLOR_RED, 1'b1,
                lbdl_pkg::LIFT_STANDSTILL, 1'b1},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_TICK, 1'b0, 1'b1, lbdl_pkg::COLOR_GREEN, 1'b0,
                lbdl_pkg::LIFT_DOWN, 1'b1},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_TICK, 1'b0, 1'b0, lbdl_pkg::COLOR_NONE, 1'b1,
                LIFT_ALARM_HIGH, 1'b0},
              1'b0, NO_RES},
            '{'{lbdl_pkg::KIND_ALARM, 1'b0, 1'b1, lbdl_pkg::COLOR_BLUE, 1'b0,
                lbdl_pkg::LIFT_UP_MOVING, 1'b0},
              1'b0, NO_RES}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].word, dir_rows[i].known, dir_rows[i].res);

        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(3, 30)),
                  16'($urandom_range(1, 5)), 16'($urandom_range(1, 4)), 1'b0, 180, 1'b0);
        run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(3, 30)),
                  16'($urandom_range(1, 5)), 16'($urandom_range(1, 4)), 1'b1, 180, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 180, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 180, 1'b1);
        calm = 1'b1;
        run_phase(16'd1, 16'd1, 16'd1, 16'd1, 1'b0, 180, 1'b0);
        calm = 1'b0;
        run_phase(16'hFFFF, 16'd0, 16'd2, 16'd0, 1'b1, 180, 1'b0);
        run_phase(16'($urandom_range(1, 200)), 16'($urandom_range(50, 400)),
                  16'($urandom_range(1, 30)), 16'($urandom_range(1, 20)), 1'b1, 180, 1'b1);
        run_phase(lbdl_pkg::RESET_DEBOUNCE, lbdl_pkg::RESET_REPEAT_GAP,
                  lbdl_pkg::RESET_BLINK_HALF, lbdl_pkg::RESET_ALARM_PERIOD,
                  1'b0, 180, 1'b0);

        drain();
        repeat (8) @(posedge clk);
        if (station_status_q.size() != 0)
        begin
            $error("%0d result words never arrived", station_status_q.size());
            errors++;
        end
        $display("Sent %0d words over 8 register settings (%0d writes), checked %0d results.",
                 words_sent, reg_writes, results_seen);
        $display("Reports seen: %0d, peak alarm nesting: %0d, mismatches: %0d.",
                 reports_seen, peak_depth, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        lbdl_pkg::result_t want;
        lbdl_pkg::result_t got;
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (result_valid && !result_stall)
            begin
                results_seen++;
                got = '{pressed, report, {led_blue, led_green, led_red}};
                if (got.report)
                    reports_seen++;
                if (station_status_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = station_status_q.pop_front();
                    if (got.pressed !== want.pressed)
                    begin
                        $error("pressed: expected %0b, got %0b", want.pressed, got.pressed);
                        errors++;
                    end
                    if (got.report !== want.report)
                    begin
                        $error("report: expected %0b, got %0b", want.report, got.report);
                        errors++;
                    end
                    if (got.led[0] !== want.led[0])
                    begin
                        $error("led_red: expected %0b, got %0b", want.led[0], got.led[0]);
                        errors++;
                    end
                    if (got.led[1] !== want.led[1])
                    begin
                        $error("led_green: expected %0b, got %0b", want.led[1], got.led[1]);
                        errors++;
                    end
                    if (got.led[2] !== want.led[2])
                    begin
                        $error("led_blue: expected %0b, got %0b", want.led[2], got.led[2]);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles.", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
hdl/lbdl_pkg.sv
hdl/lbdl_cfg_regs.sv
hdl/lbdl_core.sv
hdl/lit_button_debounce_and_led.sv
tb/tb_top.sv
